// File: sv/qrs_pkg.sv
`timescale 1ns / 1ps
// qrs_pkg: shared types and fixed widths of the quadratic root solver
// no dependencies

package qrs_pkg;

    // root class codes
    typedef enum logic [1:0] {
        CLS_TWO   = 2'd0,
        CLS_ONE   = 2'd1,
        CLS_IMAG  = 2'd2,
        CLS_AZERO = 2'd3
    } t_root_class;

    localparam int unsigned COEF_W = 32;   // coefficient and root width
    localparam int unsigned D_W    = 68;   // discriminant, padded to an even width
    localparam int unsigned SQ_N   = 34;   // square root steps, one result bit each
    localparam int unsigned ROOT_W = 34;   // square root width
    localparam int unsigned REM_W  = 36;   // square root remainder width
    localparam int unsigned MAG_W  = 34;   // numerator magnitude width
    localparam int unsigned DEN_W  = 33;   // denominator magnitude width, |2a|

    // sideband that travels beside the divider stages
    typedef struct packed {
        logic        vld;
        t_root_class cls;
        logic        neg1;
        logic        neg2;
    } t_side;

endpackage

// File: sv/qrs_div_pipe.sv
`timescale 1ns / 1ps
// qrs_div_pipe: pipelined restoring divider, one quotient bit per stage
// computes (num << FRAC_BITS) / den on magnitudes; no package needed

module qrs_div_pipe #(
    parameter int unsigned NUM_W     = 34,
    parameter int unsigned DEN_W     = 33,
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [NUM_W-1:0]           i_num,
    input  logic [DEN_W-1:0]           i_den,
    output logic [NUM_W+FRAC_BITS-1:0] o_quo
);

    localparam int unsigned QW = NUM_W + FRAC_BITS;

    logic [QW-1:0]    r_dvd [QW];
    logic [QW-1:0]    r_quo [QW];
    logic [DEN_W-1:0] r_rem [QW];
    logic [DEN_W-1:0] r_den [QW];

    genvar k;
    generate
        for (k = 0; k < QW; k++) begin : g_step
            logic [QW-1:0]    p_dvd;
            logic [QW-1:0]    p_quo;
            logic [DEN_W-1:0] p_rem;
            logic [DEN_W-1:0] p_den;
            logic [DEN_W:0]   t;
            logic             ge;
            logic [DEN_W-1:0] n_rem;

            if (k == 0) begin : g_first
                assign p_dvd = QW'(i_num) << FRAC_BITS;
                assign p_quo = '0;
                assign p_rem = '0;
                assign p_den = i_den;
            end else begin : g_next
                assign p_dvd = r_dvd[k-1];
                assign p_quo = r_quo[k-1];
                assign p_rem = r_rem[k-1];
                assign p_den = r_den[k-1];
            end

            always_comb begin
                t     = {p_rem, p_dvd[QW-1]};
                ge    = (t >= {1'b0, p_den});
                n_rem = ge ? DEN_W'(t - {1'b0, p_den}) : DEN_W'(t);
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_dvd[k] <= p_dvd << 1;
                    r_quo[k] <= {p_quo[QW-2:0], ge};
                    r_rem[k] <= n_rem;
                    r_den[k] <= p_den;
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[QW-1];

endmodule

// File: sv/quadratic_root_solver_unit.sv
`timescale 1ns / 1ps
// quadratic_root_solver_unit: real roots of a*x^2 + b*x + c in signed fixed point
// depends on qrs_pkg and qrs_div_pipe

// Takes one coefficient transaction (a, b, c) per cycle while o_stall is low and
// returns one result transaction per input, in order. The discriminant b*b - 4ac
// is formed exactly, its floor square root is taken one bit per stage, and two
// dividers, one bit per stage, form (-b -/+ sqrt) / 2a. A transaction passes the
// input, product, discriminant, square root, numerator, divider and output stages
// in that order; throughput is one transaction per cycle while o_stall is low. The
// whole pipeline advances whenever the output register is empty or being taken, so
// o_stall only rises while a finished result sits on the output under i_stall.

module quadratic_root_solver_unit
    import qrs_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_coef_a,
    input  logic [31:0] i_coef_b,
    input  logic [31:0] i_coef_c,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_root_class,
    output logic [31:0] o_root_small,
    output logic [31:0] o_root_large,
    output logic        o_overflow
);

    localparam int unsigned QW = MAG_W + FRAC_BITS;

    // global advance: the output register is free or its transaction is taken
    logic en;
    logic r_o_vld;
    assign en      = !r_o_vld || !i_stall;
    assign o_stall = !en;

    // ---------------- stage a: input register
    logic        r_a_vld;
    logic [31:0] r_a_a, r_a_b, r_a_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_a <= i_coef_a;
            r_a_b <= i_coef_b;
            r_a_c <= i_coef_c;
        end
    end

    // ---------------- stage b: magnitude products b*b and a*c
    logic [31:0] ma, mb, mc;
    logic        n_acneg;
    logic        r_b_vld, r_b_acneg, r_b_azero;
    logic [63:0] r_b_bb, r_b_p;
    logic [31:0] r_b_a, r_b_b;

    always_comb begin
        ma      = r_a_a[31] ? (32'd0 - r_a_a) : r_a_a;
        mb      = r_a_b[31] ? (32'd0 - r_a_b) : r_a_b;
        mc      = r_a_c[31] ? (32'd0 - r_a_c) : r_a_c;
        n_acneg = (r_a_a[31] ^ r_a_c[31]) && (r_a_a != '0) && (r_a_c != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_bb    <= mb * mb;
            r_b_p     <= ma * mc;
            r_b_acneg <= n_acneg;
            r_b_azero <= (r_a_a == '0);
            r_b_a     <= r_a_a;
            r_b_b     <= r_a_b;
        end
    end

    // ---------------- stage c: discriminant and class
    logic [65:0]    p4;
    logic [66:0]    bbx, n_d;
    t_root_class    n_cls;
    logic           r_c_vld;
    logic [D_W-1:0] r_c_d;
    t_root_class    r_c_cls;
    logic [31:0]    r_c_a, r_c_b;

    always_comb begin
        p4  = {r_b_p, 2'b00};
        bbx = 67'(r_b_bb);
        n_d = '0;
        priority if (r_b_azero) begin
            n_cls = CLS_AZERO;
        end else if (r_b_acneg) begin
            n_cls = CLS_TWO;
            n_d   = bbx + 67'(p4);
        end else if (bbx > 67'(p4)) begin
            n_cls = CLS_TWO;
            n_d   = bbx - 67'(p4);
        end else if (bbx == 67'(p4)) begin
            n_cls = CLS_ONE;
        end else begin
            n_cls = CLS_IMAG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_d   <= D_W'(n_d);
            r_c_cls <= n_cls;
            r_c_a   <= r_b_a;
            r_c_b   <= r_b_b;
        end
    end

    // ---------------- square root stages, one root bit each
    logic              r_s_vld  [SQ_N];
    logic [D_W-1:0]    r_s_d    [SQ_N];
    logic [REM_W-1:0]  r_s_rem  [SQ_N];
    logic [ROOT_W-1:0] r_s_root [SQ_N];
    t_root_class       r_s_cls  [SQ_N];
    logic [31:0]       r_s_a    [SQ_N];
    logic [31:0]       r_s_b    [SQ_N];

    genvar k;
    generate
        for (k = 0; k < SQ_N; k++) begin : g_sqrt
            logic              p_vld;
            logic [D_W-1:0]    p_d;
            logic [REM_W-1:0]  p_rem;
            logic [ROOT_W-1:0] p_root;
            t_root_class       p_cls;
            logic [31:0]       p_a, p_b;
            logic [REM_W+1:0]  t, trial;
            logic              ge;

            if (k == 0) begin : g_first
                assign p_vld  = r_c_vld;
                assign p_d    = r_c_d;
                assign p_rem  = '0;
                assign p_root = '0;
                assign p_cls  = r_c_cls;
                assign p_a    = r_c_a;
                assign p_b    = r_c_b;
            end else begin : g_next
                assign p_vld  = r_s_vld[k-1];
                assign p_d    = r_s_d[k-1];
                assign p_rem  = r_s_rem[k-1];
                assign p_root = r_s_root[k-1];
                assign p_cls  = r_s_cls[k-1];
                assign p_a    = r_s_a[k-1];
                assign p_b    = r_s_b[k-1];
            end

            always_comb begin
                t     = {p_rem, p_d[D_W-1 -: 2]};
                trial = (REM_W+2)'({p_root, 2'b01});
                ge    = (t >= trial);
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_s_vld[k] <= 1'b0;
                end else if (en) begin
                    r_s_vld[k] <= p_vld;
                end
            end

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_s_d[k]    <= p_d << 2;
                    r_s_rem[k]  <= ge ? REM_W'(t - trial) : REM_W'(t);
                    r_s_root[k] <= {p_root[ROOT_W-2:0], ge};
                    r_s_cls[k]  <= p_cls;
                    r_s_a[k]    <= p_a;
                    r_s_b[k]    <= p_b;
                end
            end
        end
    endgenerate

    // ---------------- numerator stage: -b - s and -b + s, denominator |2a|
    logic [35:0]      nb, s36, n1, n2;
    logic [31:0]      mag_a;
    logic             r_n_vld, r_n_neg1, r_n_neg2;
    logic [MAG_W-1:0] r_n_m1, r_n_m2;
    logic [DEN_W-1:0] r_n_den;
    t_root_class      r_n_cls;

    always_comb begin
        nb    = 36'd0 - {{4{r_s_b[SQ_N-1][31]}}, r_s_b[SQ_N-1]};
        s36   = 36'(r_s_root[SQ_N-1]);
        n1    = nb - s36;
        n2    = nb + s36;
        mag_a = r_s_a[SQ_N-1][31] ? (32'd0 - r_s_a[SQ_N-1]) : r_s_a[SQ_N-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_vld <= 1'b0;
        end else if (en) begin
            r_n_vld <= r_s_vld[SQ_N-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n_m1   <= n1[35] ? MAG_W'(36'd0 - n1) : MAG_W'(n1);
            r_n_m2   <= n2[35] ? MAG_W'(36'd0 - n2) : MAG_W'(n2);
            r_n_neg1 <= n1[35] ^ r_s_a[SQ_N-1][31];
            r_n_neg2 <= n2[35] ^ r_s_a[SQ_N-1][31];
            r_n_den  <= {mag_a, 1'b0};
            r_n_cls  <= r_s_cls[SQ_N-1];
        end
    end

    // ---------------- divider stages with matching sideband
    logic [QW-1:0] q1, q2;
    t_side         r_d_side [QW];

    qrs_div_pipe #(
        .NUM_W     (MAG_W),
        .DEN_W     (DEN_W),
        .FRAC_BITS (FRAC_BITS)
    ) u_div_lo (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_n_m1),
        .i_den (r_n_den),
        .o_quo (q1)
    );

    qrs_div_pipe #(
        .NUM_W     (MAG_W),
        .DEN_W     (DEN_W),
        .FRAC_BITS (FRAC_BITS)
    ) u_div_hi (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_n_m2),
        .i_den (r_n_den),
        .o_quo (q2)
    );

    generate
        for (k = 0; k < QW; k++) begin : g_side
            t_side p_side;
            if (k == 0) begin : g_first
                assign p_side = '{vld: r_n_vld, cls: r_n_cls, neg1: r_n_neg1, neg2: r_n_neg2};
            end else begin : g_next
                assign p_side = r_d_side[k-1];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_d_side[k].vld <= 1'b0;
                end else if (en) begin
                    r_d_side[k] <= p_side;
                end
            end
        end
    endgenerate

    // ---------------- saturation, ordering and class masking
    localparam logic [QW-1:0] Q_NEG_LIM = QW'(33'h1_0000_0000 >> 1);
    localparam logic [QW-1:0] Q_POS_LIM = QW'(32'h7FFF_FFFF);

    t_side       fin;
    logic [31:0] r1, r2, n_small, n_large;
    logic        o1, o2, n_ovf;
    logic        r_o_ovf;
    logic [1:0]  r_o_cls;
    logic [31:0] r_o_small, r_o_large;

    assign fin = r_d_side[QW-1];

    always_comb begin
        if (fin.neg1) begin
            o1 = (q1 > Q_NEG_LIM);
            r1 = o1 ? 32'h8000_0000 : (32'd0 - q1[31:0]);
        end else begin
            o1 = (q1 > Q_POS_LIM);
            r1 = o1 ? 32'h7FFF_FFFF : q1[31:0];
        end
        if (fin.neg2) begin
            o2 = (q2 > Q_NEG_LIM);
            r2 = o2 ? 32'h8000_0000 : (32'd0 - q2[31:0]);
        end else begin
            o2 = (q2 > Q_POS_LIM);
            r2 = o2 ? 32'h7FFF_FFFF : q2[31:0];
        end
        unique case (fin.cls)
            CLS_TWO: begin
                n_small = ($signed(r1) < $signed(r2)) ? r1 : r2;
                n_large = ($signed(r1) < $signed(r2)) ? r2 : r1;
                n_ovf   = o1 | o2;
            end
            CLS_ONE: begin
                n_small = r1;
                n_large = '0;
                n_ovf   = o1;
            end
            default: begin
                n_small = '0;
                n_large = '0;
                n_ovf   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_o_vld <= fin.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_cls   <= fin.cls;
            r_o_small <= n_small;
            r_o_large <= n_large;
            r_o_ovf   <= n_ovf;
        end
    end

    assign o_valid      = r_o_vld;
    assign o_root_class = r_o_cls;
    assign o_root_small = r_o_small;
    assign o_root_large = r_o_large;
    assign o_overflow   = r_o_ovf;

`ifndef ASSERT_OFF
    a_imag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_root_class == CLS_IMAG || o_root_class == CLS_AZERO)
        |-> (o_root_small == '0) && (o_root_large == '0) && !o_overflow)
        else $error("root fields not cleared for a class without roots");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_root_class == CLS_TWO) |-> $signed(o_root_small) <= $signed(o_root_large))
        else $error("distinct roots out of order");

    a_single_large: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_root_class == CLS_ONE) |-> (o_root_large == '0))
        else $error("single root with nonzero large root");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r_a_a) && $stable(r_c_d))
        else $error("pipeline moved during a stall");
`endif

endmodule
